[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmt assertion failed");

// Next-cycle implication, disabled during reset.
`define RMT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmt assertion failed");

`endif

[rtl/rmt_pkg.sv]
// Package: widths, types and helpers for the ray midpoint triangulation block.
package rmt_pkg;

   localparam int COORD_W = 32;
   localparam int SUM_W   = COORD_W + 1;          // pa+pb, pb-pa
   localparam int DOT_W   = 2 * COORD_W + 2;      // a, b, c, d, e
   localparam int DET_W   = 2 * DOT_W - 3;        // det, non-negative
   localparam int NS_W    = 2 * DOT_W - 1;        // Ns, Nt
   localparam int NUM_W   = NS_W + COORD_W + 1;   // per-axis numerator
   localparam int QUO_W   = COORD_W;
   localparam int DIGIT_W = 33;                   // multiplier digit

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   function automatic int mul_lat(input int wa, input int wb);
      return ((wa + DIGIT_W - 1) / DIGIT_W) * ((wb + DIGIT_W - 1) / DIGIT_W) + 2;
   endfunction

endpackage

[rtl/rmt_if.sv]
// Valid/ready channel interfaces for request and response transfers.
interface rmt_req_if;
   logic valid;
   logic ready;
   rmt_pkg::coord_type dir_a_x, dir_a_y, dir_a_z;
   rmt_pkg::coord_type org_a_x, org_a_y, org_a_z;
   rmt_pkg::coord_type dir_b_x, dir_b_y, dir_b_z;
   rmt_pkg::coord_type org_b_x, org_b_y, org_b_z;

   modport source (output valid, dir_a_x, dir_a_y, dir_a_z, org_a_x, org_a_y, org_a_z,
                   dir_b_x, dir_b_y, dir_b_z, org_b_x, org_b_y, org_b_z, input ready);
   modport sink (input valid, dir_a_x, dir_a_y, dir_a_z, org_a_x, org_a_y, org_a_z,
                 dir_b_x, dir_b_y, dir_b_z, org_b_x, org_b_y, org_b_z, output ready);
endinterface

interface rmt_rsp_if;
   logic valid;
   logic ready;
   rmt_pkg::coord_type mid_x, mid_y, mid_z;
   logic degenerate;

   modport source (output valid, mid_x, mid_y, mid_z, degenerate, input ready);
   modport sink (input valid, mid_x, mid_y, mid_z, degenerate, output ready);
endinterface

[rtl/ray_midpoint_triangulation.sv]
// Top level: midpoint of closest approach of two 3D lines, Q16.16 in and out.
//
//   channel | dir | fields                               | handshake
//   req_if  | in  | dir_a/org_a/dir_b/org_b x,y,z (s32)  | valid/ready
//   rsp_if  | out | mid_x/mid_y/mid_z (s32), degenerate  | valid/ready
//
// One transfer per cycle sustained while the response is not held.
// Depth is set by two 4-digit multiplier passes and the 32-step divider.
// Synchronous reset clears the valid bits only.
// A held response freezes the whole pipeline; nothing is dropped or repeated.
module ray_midpoint_triangulation (
   input logic       clock,
   input logic       reset,
   rmt_req_if.sink   req_if,
   rmt_rsp_if.source rsp_if
);
   import rmt_pkg::*;

   localparam int MUL1_LAT = mul_lat(DOT_W, DOT_W);
   localparam int MUL2_LAT = mul_lat(NS_W, SUM_W);
   localparam int DIV_LAT  = QUO_W + 1;
   localparam int S_DET    = 3 + MUL1_LAT;
   localparam int NSTG     = S_DET + MUL2_LAT + 3 + DIV_LAT + 2;
   localparam int PK       = SUM_W + 2 * COORD_W;

   logic            en;
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;

   assign en     = !vld_ff[NSTG-1] || rsp_if.ready;
   assign vld_in = {vld_ff[NSTG-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage 0: input register, sum and difference of points
   coord_type               da_in [3], pa_in [3], db_in [3], pb_in [3];
   coord_type               da_ff [3], db_ff [3];
   logic signed [SUM_W-1:0] sm_ff [3], wv_ff [3];

   assign da_in[0] = req_if.dir_a_x;
   assign da_in[1] = req_if.dir_a_y;
   assign da_in[2] = req_if.dir_a_z;
   assign pa_in[0] = req_if.org_a_x;
   assign pa_in[1] = req_if.org_a_y;
   assign pa_in[2] = req_if.org_a_z;
   assign db_in[0] = req_if.dir_b_x;
   assign db_in[1] = req_if.dir_b_y;
   assign db_in[2] = req_if.dir_b_z;
   assign pb_in[0] = req_if.org_b_x;
   assign pb_in[1] = req_if.org_b_y;
   assign pb_in[2] = req_if.org_b_z;

   // stage 1 products, stage 2 dot products
   logic signed [2*COORD_W-1:0] pr_aa_ff [3], pr_ab_ff [3], pr_bb_ff [3];
   logic signed [2*COORD_W:0]   pr_ad_ff [3], pr_bd_ff [3];
   logic signed [DOT_W-1:0]     dot_a_ff, dot_b_ff, dot_c_ff, dot_d_ff, dot_e_ff;

   for (genvar k = 0; k < 3; k++) begin : g_front
      always_ff @(posedge clock) begin
         if (en) begin
            da_ff[k]    <= da_in[k];
            db_ff[k]    <= db_in[k];
            sm_ff[k]    <= SUM_W'(pa_in[k]) + SUM_W'(pb_in[k]);
            wv_ff[k]    <= SUM_W'(pb_in[k]) - SUM_W'(pa_in[k]);
            pr_aa_ff[k] <= (2*COORD_W)'(da_ff[k]) * (2*COORD_W)'(da_ff[k]);
            pr_ab_ff[k] <= (2*COORD_W)'(da_ff[k]) * (2*COORD_W)'(db_ff[k]);
            pr_bb_ff[k] <= (2*COORD_W)'(db_ff[k]) * (2*COORD_W)'(db_ff[k]);
            pr_ad_ff[k] <= (2*COORD_W+1)'(da_ff[k]) * (2*COORD_W+1)'(wv_ff[k]);
            pr_bd_ff[k] <= (2*COORD_W+1)'(db_ff[k]) * (2*COORD_W+1)'(wv_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dot_a_ff <= DOT_W'(pr_aa_ff[0]) + DOT_W'(pr_aa_ff[1]) + DOT_W'(pr_aa_ff[2]);
         dot_b_ff <= DOT_W'(pr_ab_ff[0]) + DOT_W'(pr_ab_ff[1]) + DOT_W'(pr_ab_ff[2]);
         dot_c_ff <= DOT_W'(pr_bb_ff[0]) + DOT_W'(pr_bb_ff[1]) + DOT_W'(pr_bb_ff[2]);
         dot_d_ff <= DOT_W'(pr_ad_ff[0]) + DOT_W'(pr_ad_ff[1]) + DOT_W'(pr_ad_ff[2]);
         dot_e_ff <= DOT_W'(pr_bd_ff[0]) + DOT_W'(pr_bd_ff[1]) + DOT_W'(pr_bd_ff[2]);
      end
   end

   // second-order products
   logic signed [2*DOT_W-1:0] m_ac, m_bb, m_cd, m_be, m_bd, m_ae;

   rmt_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_ac (
      .clock(clock), .en(en), .a(dot_a_ff), .b(dot_c_ff), .p(m_ac));
   rmt_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_bb (
      .clock(clock), .en(en), .a(dot_b_ff), .b(dot_b_ff), .p(m_bb));
   rmt_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_cd (
      .clock(clock), .en(en), .a(dot_c_ff), .b(dot_d_ff), .p(m_cd));
   rmt_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_be (
      .clock(clock), .en(en), .a(dot_b_ff), .b(dot_e_ff), .p(m_be));
   rmt_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_bd (
      .clock(clock), .en(en), .a(dot_b_ff), .b(dot_d_ff), .p(m_bd));
   rmt_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_ae (
      .clock(clock), .en(en), .a(dot_a_ff), .b(dot_e_ff), .p(m_ae));

   logic signed [DET_W-1:0] det_ff;
   logic signed [NS_W-1:0]  ns_ff, nt_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= DET_W'(m_ac - m_bb);
         ns_ff  <= NS_W'(m_cd - m_be);
         nt_ff  <= NS_W'(m_bd - m_ae);
      end
   end

   // per-axis operands delayed to line up with det/Ns/Nt
   logic [3*PK-1:0] dly_in, dly_out;

   for (genvar k = 0; k < 3; k++) begin : g_pack
      assign dly_in[k*PK +: PK] = {sm_ff[k], da_ff[k], db_ff[k]};
   end

   rmt_dly #(.W(3*PK), .N(S_DET)) u_dly_axis (
      .clock(clock), .en(en), .din(dly_in), .dout(dly_out));

   logic [DET_W-1:0] det_d;

   rmt_dly #(.W(DET_W), .N(MUL2_LAT + 2)) u_dly_det (
      .clock(clock), .en(en), .din(det_ff), .dout(det_d));

   logic [DET_W-1:0] dd_ff;
   logic             deg_s_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dd_ff    <= {det_d[DET_W-2:0], 1'b0};
         deg_s_ff <= (det_d == '0);
      end
   end

   coord_type mid_ff [3];
   logic      deg_ff;
   logic [1:0] side_o [3];

   for (genvar k = 0; k < 3; k++) begin : g_axis
      logic signed [SUM_W-1:0]       sm_d;
      coord_type                     da_d, db_d;
      logic signed [DET_W+SUM_W-1:0] p_s;
      logic signed [NS_W+COORD_W-1:0] p_a, p_b;
      logic signed [NUM_W-1:0]       num_ff;
      logic [NUM_W-1:0]              mag_ff, nn_ff;
      logic                          neg_ff, neg_s_ff;
      logic [QUO_W-1:0]              quo;
      logic                          ovf;
      logic                          sat;
      coord_type                     mid_in;

      assign sm_d = dly_out[k*PK + 2*COORD_W +: SUM_W];
      assign da_d = dly_out[k*PK + COORD_W +: COORD_W];
      assign db_d = dly_out[k*PK +: COORD_W];

      rmt_mul #(.WA(DET_W), .WB(SUM_W)) u_mul_s (
         .clock(clock), .en(en), .a(det_ff), .b(sm_d), .p(p_s));
      rmt_mul #(.WA(NS_W), .WB(COORD_W)) u_mul_a (
         .clock(clock), .en(en), .a(ns_ff), .b(da_d), .p(p_a));
      rmt_mul #(.WA(NS_W), .WB(COORD_W)) u_mul_b (
         .clock(clock), .en(en), .a(nt_ff), .b(db_d), .p(p_b));

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff   <= NUM_W'(p_s) + NUM_W'(p_a) + NUM_W'(p_b);
            neg_ff   <= num_ff[NUM_W-1];
            mag_ff   <= num_ff[NUM_W-1] ? $unsigned(-num_ff) : $unsigned(num_ff);
            neg_s_ff <= neg_ff;
            nn_ff    <= mag_ff + NUM_W'(det_d);
         end
      end

      rmt_div #(.NW(NUM_W), .DW(DET_W), .QW(QUO_W), .SW(2)) u_div (
         .clock(clock), .en(en), .num(nn_ff), .den(dd_ff),
         .side({deg_s_ff, neg_s_ff}), .quo(quo), .ovf(ovf), .side_out(side_o[k]));

      // q with top bit set is out of range either way; -2^31 saturates to itself
      assign sat = ovf || quo[QUO_W-1];

      always_comb begin
         if (side_o[k][1]) begin
            mid_in = '0;
         end else if (side_o[k][0]) begin
            mid_in = sat ? SAT_MIN : -$signed(quo);
         end else begin
            mid_in = sat ? SAT_MAX : $signed(quo);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            mid_ff[k] <= mid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         deg_ff <= side_o[0][1];
      end
   end

   assign req_if.ready      = en;
   assign rsp_if.valid      = vld_ff[NSTG-1];
   assign rsp_if.mid_x      = mid_ff[0];
   assign rsp_if.mid_y      = mid_ff[1];
   assign rsp_if.mid_z      = mid_ff[2];
   assign rsp_if.degenerate = deg_ff;
endmodule

[rtl/rmt_dly.sv]
// Enabled delay line of N register stages.
module rmt_dly #(
   parameter int W = 8,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);
   logic [W-1:0] sr_ff [0:N-1];

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= din;
      end
   end

   for (genvar i = 1; i < N; i++) begin : g_sr
      always_ff @(posedge clock) begin
         if (en) begin
            sr_ff[i] <= sr_ff[i-1];
         end
      end
   end

   assign dout = sr_ff[N-1];
endmodule

[rtl/rmt_mul.sv]
// Pipelined signed multiplier, one digit partial product per stage.
module rmt_mul #(
   parameter int WA = 66,
   parameter int WB = 66
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [WA-1:0]    a,
   input  logic signed [WB-1:0]    b,
   output logic signed [WA+WB-1:0] p
);
   import rmt_pkg::*;

   localparam int WP = WA + WB;
   localparam int NA = (WA + DIGIT_W - 1) / DIGIT_W;
   localparam int NB = (WB + DIGIT_W - 1) / DIGIT_W;
   localparam int NP = NA * NB;
   localparam int AW = NA * DIGIT_W;
   localparam int BW = NB * DIGIT_W;

   logic [AW-1:0]        am_ff  [0:NP];
   logic [BW-1:0]        bm_ff  [0:NP];
   logic [WP-1:0]        acc_ff [0:NP];
   logic                 neg_ff [0:NP];
   logic signed [WP-1:0] p_ff;
   logic [WA-1:0]        am_in;
   logic [WB-1:0]        bm_in;

   assign am_in = a[WA-1] ? $unsigned(-a) : $unsigned(a);
   assign bm_in = b[WB-1] ? $unsigned(-b) : $unsigned(b);

   always_ff @(posedge clock) begin
      if (en) begin
         am_ff[0]  <= AW'(am_in);
         bm_ff[0]  <= BW'(bm_in);
         acc_ff[0] <= '0;
         neg_ff[0] <= a[WA-1] ^ b[WB-1];
      end
   end

   for (genvar k = 1; k <= NP; k++) begin : g_pp
      localparam int IA = (k - 1) / NB;
      localparam int IB = (k - 1) % NB;
      localparam int SH = (IA + IB) * DIGIT_W;
      logic [2*DIGIT_W-1:0] pp;
      logic [WP-1:0]        pp_sh;

      assign pp = (2*DIGIT_W)'(am_ff[k-1][IA*DIGIT_W +: DIGIT_W])
                * (2*DIGIT_W)'(bm_ff[k-1][IB*DIGIT_W +: DIGIT_W]);
      assign pp_sh = WP'(pp) << SH;

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_ff[k-1] + pp_sh;
            am_ff[k]  <= am_ff[k-1];
            bm_ff[k]  <= bm_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= neg_ff[NP] ? -$signed(acc_ff[NP]) : $signed(acc_ff[NP]);
      end
   end

   assign p = p_ff;
endmodule

[rtl/rmt_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rmt_div #(
   parameter int NW = 164,
   parameter int DW = 129,
   parameter int QW = 32,
   parameter int SW = 2
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side,
   output logic [QW-1:0] quo,
   output logic          ovf,
   output logic [SW-1:0] side_out
);
   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic [DW-1:0] rem_ff  [0:QW];
   logic [QW-1:0] q_ff    [0:QW];
   logic [QW-1:0] lo_ff   [0:QW];
   logic [DW-1:0] den_ff  [0:QW];
   logic          ovf_ff  [0:QW];
   logic [SW-1:0] side_ff [0:QW];

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0]  <= CW'(num) >= (CW'(den) << QW);
         rem_ff[0]  <= DW'(num >> QW);
         lo_ff[0]   <= num[QW-1:0];
         q_ff[0]    <= '0;
         den_ff[0]  <= den;
         side_ff[0] <= side;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [DW:0] t;
      logic        ge;

      assign t  = {rem_ff[k-1], lo_ff[k-1][QW-k]};
      assign ge = t >= {1'b0, den_ff[k-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? DW'(t - {1'b0, den_ff[k-1]}) : DW'(t);
            q_ff[k]    <= {q_ff[k-1][QW-2:0], ge};
            lo_ff[k]   <= lo_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign quo      = q_ff[QW];
   assign ovf      = ovf_ff[QW];
   assign side_out = side_ff[QW];
endmodule

[rtl/rmt_chk.sv]
// Port-level checker for the triangulation block, bound to the top level.
`include "assert_macros.svh"

module rmt_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input rmt_pkg::coord_type rsp_mid_x,
   input rmt_pkg::coord_type rsp_mid_y,
   input rmt_pkg::coord_type rsp_mid_z,
   input logic               rsp_degenerate
);
   `RMT_ASSERT_IMP(a_deg_zero, clock, reset, rsp_valid && rsp_degenerate,
      rsp_mid_x == 0 && rsp_mid_y == 0 && rsp_mid_z == 0)
   `RMT_ASSERT_IMP(a_open_when_empty, clock, reset, !rsp_valid, req_ready)
   `RMT_ASSERT_IMP(a_stall_backs_up, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `RMT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_mid_x) && $stable(rsp_degenerate))
endmodule

bind ray_midpoint_triangulation rmt_chk u_rmt_chk (
   .clock(clock),
   .reset(reset),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_mid_x(rsp_if.mid_x),
   .rsp_mid_y(rsp_if.mid_y),
   .rsp_mid_z(rsp_if.mid_z),
   .rsp_degenerate(rsp_if.degenerate)
);

[tb/sv/testbench.sv]
// Testbench for ray_midpoint_triangulation: directed table plus random lines, scoreboarded.
module testbench;
   import rmt_pkg::*;

   typedef struct {
      coord_type dir_a_x, dir_a_y, dir_a_z, org_a_x, org_a_y, org_a_z;
      coord_type dir_b_x, dir_b_y, dir_b_z, org_b_x, org_b_y, org_b_z;
   } line_pair_type;

   typedef struct {
      coord_type mid_x, mid_y, mid_z;
      logic      degenerate;
   } midpoint_type;

   typedef struct {
      line_pair_type lines;
      logic          has_fixed;
      midpoint_type  fixed;
   } stim_row_type;

   localparam int DRAIN_CYCLES = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   rmt_req_if req_if();
   rmt_rsp_if rsp_if();

   ray_midpoint_triangulation u_top (
      .clock(clock),
      .reset(reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   midpoint_type midpoint_queue[$];
   stim_row_type table_rows[$];
   int  error_count = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  recv_hold = 1'b0;

   function automatic logic signed [31:0] round_sat_coord(logic signed [255:0] num,
                                                          logic signed [255:0] det);
      logic signed [255:0] mag;
      logic signed [255:0] quo;
      mag = (num < 0) ? -num : num;
      quo = (mag + det) / (2 * det);
      if (num < 0) begin
         if (quo > 256'sd2147483648) return SAT_MIN;
         return -quo[31:0];
      end
      if (quo > 256'sd2147483647) return SAT_MAX;
      return quo[31:0];
   endfunction

   function automatic midpoint_type predict_midpoint(line_pair_type l);
      logic signed [255:0] da[3], pa[3], db[3], pb[3], w[3];
      logic signed [255:0] a, b, c, d, e, det, ns, nt, num;
      midpoint_type m;
      da[0] = l.dir_a_x; da[1] = l.dir_a_y; da[2] = l.dir_a_z;
      pa[0] = l.org_a_x; pa[1] = l.org_a_y; pa[2] = l.org_a_z;
      db[0] = l.dir_b_x; db[1] = l.dir_b_y; db[2] = l.dir_b_z;
      pb[0] = l.org_b_x; pb[1] = l.org_b_y; pb[2] = l.org_b_z;
      a = 0; b = 0; c = 0; d = 0; e = 0;
      for (int k = 0; k < 3; k++) begin
         w[k] = pb[k] - pa[k];
         a += da[k] * da[k];
         b += da[k] * db[k];
         c += db[k] * db[k];
         d += da[k] * w[k];
         e += db[k] * w[k];
      end
      det = a * c - b * b;
      m = '{0, 0, 0, 1'b1};
      if (det == 0) return m;
      ns = c * d - b * e;
      nt = b * d - a * e;
      m.degenerate = 1'b0;
      for (int k = 0; k < 3; k++) begin
         num = (pa[k] + pb[k]) * det + ns * da[k] + nt * db[k];
         case (k)
            0: m.mid_x = round_sat_coord(num, det);
            1: m.mid_y = round_sat_coord(num, det);
            default: m.mid_z = round_sat_coord(num, det);
         endcase
      end
      return m;
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return $urandom_range(0, 8) - 4;
         3, 4: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         5, 6: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic line_pair_type rand_lines();
      line_pair_type l;
      int s;
      l = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord()};
      if ($urandom_range(0, 9) == 0) begin
         // parallel: dir_b is an integer multiple of dir_a
         s = $urandom_range(0, 6) - 3;
         l.dir_a_x = $signed(l.dir_a_x) >>> 3;
         l.dir_a_y = $signed(l.dir_a_y) >>> 3;
         l.dir_a_z = $signed(l.dir_a_z) >>> 3;
         l.dir_b_x = l.dir_a_x * s;
         l.dir_b_y = l.dir_a_y * s;
         l.dir_b_z = l.dir_a_z * s;
      end
      return l;
   endfunction

   task automatic add_row(line_pair_type l, logic has_fixed, midpoint_type fixed);
      stim_row_type row;
      row.lines     = l;
      row.has_fixed = has_fixed;
      row.fixed     = fixed;
      table_rows = {table_rows, row};
   endtask

   task automatic enqueue_expected(midpoint_type m);
      midpoint_queue = {midpoint_queue, m};
   endtask

   task automatic send_lines(line_pair_type l, logic has_fixed, midpoint_type fixed);
      midpoint_type m;
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      m = predict_midpoint(l);
      if (has_fixed && (m.mid_x !== fixed.mid_x || m.mid_y !== fixed.mid_y ||
                        m.mid_z !== fixed.mid_z || m.degenerate !== fixed.degenerate)) begin
         $display("%0t table row disagrees: table %p predicted %p", $realtime, fixed, m);
         error_count++;
      end
      req_if.valid <= 1'b1;
      {req_if.dir_a_x, req_if.dir_a_y, req_if.dir_a_z} <= {l.dir_a_x, l.dir_a_y, l.dir_a_z};
      {req_if.org_a_x, req_if.org_a_y, req_if.org_a_z} <= {l.org_a_x, l.org_a_y, l.org_a_z};
      {req_if.dir_b_x, req_if.dir_b_y, req_if.dir_b_z} <= {l.dir_b_x, l.dir_b_y, l.dir_b_z};
      {req_if.org_b_x, req_if.org_b_y, req_if.org_b_z} <= {l.org_b_x, l.org_b_y, l.org_b_z};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      enqueue_expected(has_fixed ? fixed : m);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset || recv_hold)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= !(recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      midpoint_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.mid_x, rsp_if.mid_y, rsp_if.mid_z, rsp_if.degenerate};
         if (midpoint_queue.size() == 0) begin
            $display("%0t unexpected transfer: actual %p", $realtime, got);
            error_count++;
         end else begin
            want = midpoint_queue.pop_front();
            if (got.mid_x !== want.mid_x || got.mid_y !== want.mid_y ||
                got.mid_z !== want.mid_z || got.degenerate !== want.degenerate) begin
               $display("%0t mismatch: expected %p actual %p", $realtime, want, got);
               error_count++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("[ray_midpoint_triangulation] ERROR");
      $finish;
   end

   initial begin
      midpoint_type none;
      int phase_idle[3][2];
      int wait_cycles;
      none = '{0, 0, 0, 1'b0};
      phase_idle = '{'{22, 61}, '{61, 22}, '{0, 0}};
      req_if.valid = 1'b0;
      {req_if.dir_a_x, req_if.dir_a_y, req_if.dir_a_z} = '0;
      {req_if.org_a_x, req_if.org_a_y, req_if.org_a_z} = '0;
      {req_if.dir_b_x, req_if.dir_b_y, req_if.dir_b_z} = '0;
      {req_if.org_b_x, req_if.org_b_y, req_if.org_b_z} = '0;
      rsp_if.ready = 1'b0;
      // all zero: degenerate
      add_row('{0,0,0,0,0,0,0,0,0,0,0,0}, 1'b1, '{0, 0, 0, 1'b1});
      // x axis through origin and y axis through (0,0,2): midpoint (0,0,1)
      add_row('{32'sh10000,0,0,0,0,0,0,32'sh10000,0,0,0,32'sh20000},
              1'b1, '{0, 0, 32'sh10000, 1'b0});
      // parallel lines
      add_row('{1,2,3,5,6,7,-2,-4,-6,8,9,10}, 1'b1, '{0, 0, 0, 1'b1});
      // crossing axes far out: saturate high and low
      add_row('{1,0,0,SAT_MAX,SAT_MAX,0,0,1,0,SAT_MAX,SAT_MAX,0},
              1'b1, '{SAT_MAX, SAT_MAX, 0, 1'b0});
      add_row('{1,0,0,SAT_MIN,SAT_MIN,SAT_MIN,0,1,0,SAT_MIN,SAT_MIN,SAT_MIN},
              1'b1, '{SAT_MIN, SAT_MIN, SAT_MIN, 1'b0});
      add_row('{SAT_MAX,SAT_MIN,SAT_MAX,SAT_MIN,SAT_MAX,SAT_MIN,
                SAT_MIN,SAT_MIN,SAT_MAX,SAT_MAX,SAT_MIN,SAT_MAX}, 1'b0, none);
      add_row('{SAT_MIN,SAT_MIN,SAT_MIN,SAT_MAX,SAT_MAX,SAT_MAX,
                1,-1,0,-1,1,SAT_MIN}, 1'b0, none);
      add_row('{-1,-1,-1,-1,-1,-1,1,0,-1,0,0,0}, 1'b0, none);
      // rounding ties
      add_row('{1,0,0,0,0,0,0,1,0,0,0,1}, 1'b0, none);
      add_row('{1,0,0,0,0,0,0,1,0,0,0,-1}, 1'b0, none);
      add_row('{1,0,0,0,0,0,0,1,0,0,0,-3}, 1'b0, none);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (table_rows[i])
         send_lines(table_rows[i].lines, table_rows[i].has_fixed, table_rows[i].fixed);
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = phase_idle[p][0];
         recv_idle_pct = phase_idle[p][1];
         for (int n = 0; n < 410; n++) begin
            if (p == 2 && n == 50) begin
               recv_hold = 1'b1;
               fork
                  begin
                     repeat (300) @(posedge clock);
                     recv_hold = 1'b0;
                  end
               join_none
            end
            if (p == 2 && n == 250) begin
               req_if.valid <= 1'b0;
               while (midpoint_queue.size() != 0) @(negedge clock);
            end
            send_lines(rand_lines(), 1'b0, none);
         end
      end
      req_if.valid <= 1'b0;
      wait_cycles = 0;
      while (midpoint_queue.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && midpoint_queue.size() == 0)
         $display("[ray_midpoint_triangulation] OK");
      else
         $display("[ray_midpoint_triangulation] ERROR");
      $finish;
   end
endmodule
